FILE: rtl/color_space_to_rgb_unit_assert.svh
// Assertion macros shared by the checker of the color space converter.
// Each macro names the assertion, gives its clock and disable term, and
// reports through $error when the property fails.
`ifndef COLOR_SPACE_TO_RGB_UNIT_ASSERT_SVH
`define COLOR_SPACE_TO_RGB_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSTR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSTR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/cstr_pkg.sv
package cstr_pkg;

   // Channel and hue number formats.
   localparam int CHANNEL_BITS      = 8;
   localparam int HUE_FRACTION_BITS = 6;
   localparam int CH_W              = CHANNEL_BITS;
   localparam int HUE_W             = 16;
   localparam int MAXV              = (1 << CHANNEL_BITS) - 1;

   // One hue sector is 60 degrees. Since 60 = 15 * 4, the sector number is
   // (hue >> SECTOR_SHIFT) / 15, and that small quotient is taken by a
   // reciprocal multiply that is exact over the whole coarse range.
   localparam int SECTOR        = 60 << HUE_FRACTION_BITS;
   localparam int SEC_W         = $clog2(SECTOR + 1);
   localparam int SECTOR_SHIFT  = HUE_FRACTION_BITS + 2;
   localparam int COARSE_W      = HUE_W - SECTOR_SHIFT;
   localparam int RECIP15       = 273;
   localparam int RECIP15_SHIFT = 12;
   localparam int SEC_PROD_W    = COARSE_W + 1 + 9;
   localparam int SECT_W        = 5;
   localparam int LAST_SECTOR   = 5;

   // Intermediate widths of the color math.
   localparam int PROD_W    = 2 * CH_W;
   localparam int HSV_P_W   = 20;
   localparam int HSL_AX_W  = 29;
   localparam int HSL_T_W   = 17;
   localparam int HSL_U_W   = 18;

   // Constant divider: quotient estimate by reciprocal, then one correction.
   localparam int NUM_W       = 30;
   localparam int RECIP_SHIFT = NUM_W;
   localparam int RECIP_W     = 23;
   localparam int DIV_W       = 21;
   localparam int QW          = CH_W + 1;
   localparam int EST_W       = NUM_W + RECIP_W;

   localparam longint D_MAXV     = MAXV;
   localparam longint D_TWO_MAXV = 2 * MAXV;
   localparam longint D_HSV_X    = MAXV * SECTOR;
   localparam longint D_HSL_X    = 2 * MAXV * SECTOR;

   localparam longint R_MAXV     = (longint'(1) << RECIP_SHIFT) / D_MAXV;
   localparam longint R_TWO_MAXV = (longint'(1) << RECIP_SHIFT) / D_TWO_MAXV;
   localparam longint R_HSV_X    = (longint'(1) << RECIP_SHIFT) / D_HSV_X;
   localparam longint R_HSL_X    = (longint'(1) << RECIP_SHIFT) / D_HSL_X;

   // Three divider lanes: zero part, x part and chroma part for HSV and HSL,
   // and red, green, blue for CMYK.
   localparam int LANES  = 3;
   localparam int LANE_Z = 0;
   localparam int LANE_X = 1;
   localparam int LANE_C = 2;

   // Pipeline stages.
   localparam int NUM_STAGES = 6;
   localparam int STG_DECODE = 0;
   localparam int STG_PROD   = 1;
   localparam int STG_PART   = 2;
   localparam int STG_NUMER  = 3;
   localparam int STG_EST    = 4;
   localparam int STG_OUT    = 5;

   typedef enum logic [1:0] {
      OP_HSV  = 2'd0,
      OP_HSL  = 2'd1,
      OP_CMYK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      DIV_MAXV     = 2'd0,
      DIV_TWO_MAXV = 2'd1,
      DIV_HSV_X    = 2'd2,
      DIV_HSL_X    = 2'd3
   } div_sel_type;

   typedef struct packed {
      logic [1:0]       operation;
      logic [HUE_W-1:0] hue;
      logic [7:0]       saturation;
      logic [7:0]       brightness;
      logic [7:0]       cyan;
      logic [7:0]       magenta;
      logic [7:0]       yellow;
      logic [7:0]       black;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

   // What the channel selection at the end needs from the front.
   typedef struct packed {
      logic [1:0] op;
      logic       oor;
      logic [2:0] sector;
   } side_type;

   typedef struct packed {
      side_type           side;
      logic [CH_W-1:0]    bright;
      logic [PROD_W-1:0]  bns;
      logic [PROD_W-1:0]  pc;
      logic [PROD_W-1:0]  pm;
      logic [PROD_W-1:0]  py;
      logic [HSV_P_W-1:0] hsv_p;
      logic [HSL_AX_W-1:0] hsl_ax2;
      logic [HSL_T_W-1:0] hsl_t;
      logic [HSL_U_W-1:0] hsl_u;
   } front_type;

   typedef struct packed {
      side_type                     side;
      logic [LANES-1:0][NUM_W-1:0]  num;
      div_sel_type [LANES-1:0]      sel;
   } numer_type;

   function automatic logic [DIV_W-1:0] div_value(div_sel_type sel);
      logic [DIV_W-1:0] d;
      case (sel)
         DIV_MAXV:     d = DIV_W'(D_MAXV);
         DIV_TWO_MAXV: d = DIV_W'(D_TWO_MAXV);
         DIV_HSV_X:    d = DIV_W'(D_HSV_X);
         DIV_HSL_X:    d = DIV_W'(D_HSL_X);
         default:      d = DIV_W'(D_MAXV);
      endcase
      return d;
   endfunction

   function automatic logic [RECIP_W-1:0] div_recip(div_sel_type sel);
      logic [RECIP_W-1:0] r;
      case (sel)
         DIV_MAXV:     r = RECIP_W'(R_MAXV);
         DIV_TWO_MAXV: r = RECIP_W'(R_TWO_MAXV);
         DIV_HSV_X:    r = RECIP_W'(R_HSV_X);
         DIV_HSL_X:    r = RECIP_W'(R_HSL_X);
         default:      r = RECIP_W'(R_MAXV);
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/cstr_pipe_ctrl.sv
module cstr_pipe_ctrl
   import cstr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          rsp_stall,
   output pipe_ctrl_type ctrl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;

   // A stage loads when it is empty or when the stage after it moves on,
   // so bubbles are squeezed out and a stall only holds full stages.
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   // Valid bits travel with the data of each stage.
   always_comb begin
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.en    = en;
   assign ctrl.valid = valid_ff;

endmodule

FILE: rtl/cstr_front.sv
module cstr_front
   import cstr_pkg::*;
(
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  req_type       req_data,
   output front_type     front
);

   // Decode stage registers.
   req_type             req_ff;
   logic [SECT_W-1:0]   sector0_ff;
   logic [SECT_W-1:0]   sector0_in;
   logic [COARSE_W:0]   coarse_in;
   logic [SEC_PROD_W-1:0] sec_prod;

   // Product stage registers.
   side_type            side1_ff;
   side_type            side1_in;
   logic [SEC_W-1:0]    xf1_ff;
   logic [SEC_W-1:0]    xf1_in;
   logic [CH_W-1:0]     sat1_ff;
   logic [CH_W-1:0]     bright1_ff;
   logic [PROD_W-1:0]   hsl_as1_ff;
   logic [PROD_W-1:0]   hsl_as1_in;
   logic [PROD_W-1:0]   bns1_ff;
   logic [PROD_W-1:0]   bns1_in;
   logic [PROD_W-1:0]   pc1_ff;
   logic [PROD_W-1:0]   pc1_in;
   logic [PROD_W-1:0]   pm1_ff;
   logic [PROD_W-1:0]   pm1_in;
   logic [PROD_W-1:0]   py1_ff;
   logic [PROD_W-1:0]   py1_in;
   logic [HUE_W:0]      sec_off;
   logic [HUE_W:0]      hue_off;
   logic [SEC_W-1:0]    frac;
   logic [CH_W:0]       twol0;
   logic [CH_W-1:0]     span;
   logic [CH_W-1:0]     kk;

   // Partial term stage registers.
   front_type           front_ff;
   front_type           front_in;
   logic [HSL_U_W-1:0]  hsl_sc;

   // Sector number: floor(hue / SECTOR) from the coarse hue bits.
   always_comb begin
      coarse_in  = {1'b0, req_data.hue[HUE_W-1:SECTOR_SHIFT]} + (COARSE_W + 1)'(1);
      sec_prod   = SEC_PROD_W'(coarse_in) * SEC_PROD_W'(RECIP15);
      sector0_in = sec_prod[RECIP15_SHIFT +: SECT_W];
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[STG_DECODE]) begin
         req_ff     <= req_data;
         sector0_ff <= sector0_in;
      end
   end

   // Position inside the sector, folded for odd sectors, and the first
   // products of the HSV, HSL and CMYK math.
   always_comb begin
      sec_off = (HUE_W + 1)'(sector0_ff) * (HUE_W + 1)'(SECTOR);
      hue_off = (HUE_W + 1)'(req_ff.hue) - sec_off;
      frac    = hue_off[SEC_W-1:0];
      xf1_in  = sector0_ff[0] ? (SEC_W'(SECTOR) - frac) : frac;

      side1_in.op     = req_ff.operation;
      side1_in.oor    = (sector0_ff > SECT_W'(LAST_SECTOR));
      side1_in.sector = sector0_ff[2:0];

      // HSL chroma span: MAXV - |2L - MAXV|.
      twol0 = {req_ff.brightness, 1'b0};
      if (twol0 <= (CH_W + 1)'(MAXV)) begin
         span = twol0[CH_W-1:0];
      end else begin
         span = CH_W'((CH_W + 1)'(2 * MAXV) - twol0);
      end
      hsl_as1_in = PROD_W'(span) * PROD_W'(req_ff.saturation);
      bns1_in    = PROD_W'(req_ff.brightness) * PROD_W'(CH_W'(MAXV) - req_ff.saturation);

      kk     = CH_W'(MAXV) - req_ff.black;
      pc1_in = PROD_W'(CH_W'(MAXV) - req_ff.cyan) * PROD_W'(kk);
      pm1_in = PROD_W'(CH_W'(MAXV) - req_ff.magenta) * PROD_W'(kk);
      py1_in = PROD_W'(CH_W'(MAXV) - req_ff.yellow) * PROD_W'(kk);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[STG_PROD]) begin
         side1_ff   <= side1_in;
         xf1_ff     <= xf1_in;
         sat1_ff    <= req_ff.saturation;
         bright1_ff <= req_ff.brightness;
         hsl_as1_ff <= hsl_as1_in;
         bns1_ff    <= bns1_in;
         pc1_ff     <= pc1_in;
         pm1_ff     <= pm1_in;
         py1_ff     <= py1_in;
      end
   end

   // Terms that scale with the sector position, plus the HSL terms that do not.
   always_comb begin
      front_in.side   = side1_ff;
      front_in.bright = bright1_ff;
      front_in.bns    = bns1_ff;
      front_in.pc     = pc1_ff;
      front_in.pm     = pm1_ff;
      front_in.py     = py1_ff;

      front_in.hsv_p = HSV_P_W'(sat1_ff) * HSV_P_W'(xf1_ff)
                     + HSV_P_W'(CH_W'(MAXV) - sat1_ff) * HSV_P_W'(SECTOR);
      front_in.hsl_ax2 = HSL_AX_W'({hsl_as1_ff, 1'b0}) * HSL_AX_W'(xf1_ff);

      hsl_sc         = HSL_U_W'({bright1_ff, 1'b0}) * HSL_U_W'(MAXV);
      front_in.hsl_t = HSL_T_W'(hsl_sc - HSL_U_W'(hsl_as1_ff));
      front_in.hsl_u = hsl_sc + HSL_U_W'(hsl_as1_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[STG_PART]) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

FILE: rtl/cstr_numer.sv
module cstr_numer
   import cstr_pkg::*;
(
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  front_type     front,
   output numer_type     numer
);

   numer_type        numer_ff;
   numer_type        numer_in;
   logic [NUM_W-1:0] hsv_nx;
   logic [NUM_W-1:0] hsv_nc;
   logic [NUM_W-1:0] hsl_nx;

   // Full numerators of every lane and the divisor that goes with each.
   always_comb begin
      hsv_nx = NUM_W'(front.bright) * NUM_W'(front.hsv_p);
      hsv_nc = NUM_W'(front.bright) * NUM_W'(MAXV);
      hsl_nx = NUM_W'(front.hsl_t) * NUM_W'(SECTOR) + NUM_W'(front.hsl_ax2);

      numer_in.side = front.side;
      unique case (front.side.op)
         OP_HSV: begin
            numer_in.num[LANE_Z] = NUM_W'(front.bns);
            numer_in.num[LANE_X] = hsv_nx;
            numer_in.num[LANE_C] = hsv_nc;
            numer_in.sel[LANE_Z] = DIV_MAXV;
            numer_in.sel[LANE_X] = DIV_HSV_X;
            numer_in.sel[LANE_C] = DIV_MAXV;
         end
         OP_HSL: begin
            numer_in.num[LANE_Z] = NUM_W'(front.hsl_t);
            numer_in.num[LANE_X] = hsl_nx;
            numer_in.num[LANE_C] = NUM_W'(front.hsl_u);
            numer_in.sel[LANE_Z] = DIV_TWO_MAXV;
            numer_in.sel[LANE_X] = DIV_HSL_X;
            numer_in.sel[LANE_C] = DIV_TWO_MAXV;
         end
         OP_CMYK: begin
            numer_in.num[0] = NUM_W'(front.pc);
            numer_in.num[1] = NUM_W'(front.pm);
            numer_in.num[2] = NUM_W'(front.py);
            numer_in.sel[LANE_Z] = DIV_MAXV;
            numer_in.sel[LANE_X] = DIV_MAXV;
            numer_in.sel[LANE_C] = DIV_MAXV;
         end
         default: begin
            // The unused operation code gives black.
            numer_in.num = '0;
            numer_in.sel[LANE_Z] = DIV_MAXV;
            numer_in.sel[LANE_X] = DIV_MAXV;
            numer_in.sel[LANE_C] = DIV_MAXV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[STG_NUMER]) begin
         numer_ff <= numer_in;
      end
   end

   assign numer = numer_ff;

endmodule

FILE: rtl/cstr_const_div.sv
module cstr_const_div
   import cstr_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  logic [NUM_W-1:0] num,
   input  div_sel_type     sel,
   output logic [CH_W-1:0] quo
);

   logic [NUM_W-1:0]  num_ff;
   div_sel_type       sel_ff;
   logic [QW-1:0]     q0_ff;
   logic [QW-1:0]     q0_in;
   logic [EST_W-1:0]  est;
   logic [DIV_W-1:0]  dval;
   logic [NUM_W-1:0]  qd;
   logic [NUM_W-1:0]  rem;
   logic [QW-1:0]     q_sum;

   // The reciprocal estimate is never above the true quotient and at most
   // one below it.
   always_comb begin
      est   = EST_W'(num) * EST_W'(div_recip(sel));
      q0_in = est[RECIP_SHIFT +: QW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num;
         sel_ff <= sel;
         q0_ff  <= q0_in;
      end
   end

   // One compare of the remainder fixes the estimate.
   always_comb begin
      dval  = div_value(sel_ff);
      qd    = NUM_W'(q0_ff) * NUM_W'(dval);
      rem   = num_ff - qd;
      q_sum = q0_ff + QW'(rem >= NUM_W'(dval));
   end

   assign quo = q_sum[CH_W-1:0];

endmodule

FILE: rtl/color_space_to_rgb_unit.sv
// Converts one pixel per transfer from HSV, HSL or CMYK into 8-bit RGB, as
// chosen by the operation field (0 HSV, 1 HSL, 2 CMYK, 3 gives black). Hue
// counts in 1/64 degree; a hue of 360 degrees or more gives gray at the
// minimum level m on all three channels. Every channel is the floor of the
// exact rational result. The unit takes one pixel every clock unless the
// input is stalled, and returns each result through a six-stage pipeline
// (hue decode, products, sector terms, numerators, reciprocal quotient
// estimate, correction and channel select into the output register). The
// constant divisions by 255 and its multiples use a reciprocal multiply and
// one remainder check. A stall on the result side holds the full stages only;
// empty stages keep filling, so the input is stalled only when every stage
// holds a pixel.
module color_space_to_rgb_unit
   import cstr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   pipe_ctrl_type         ctrl;
   front_type             front;
   numer_type             numer;
   logic [LANES-1:0][CH_W-1:0] quo;
   side_type              side4_ff;
   rsp_type               out_ff;
   rsp_type               out_in;
   logic [CH_W-1:0]       zv;
   logic [CH_W-1:0]       xv;
   logic [CH_W-1:0]       cv;

   cstr_pipe_ctrl u_pipe_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   cstr_front u_front (
      .clock    (clock),
      .ctrl     (ctrl),
      .req_data (req_data),
      .front    (front)
   );

   cstr_numer u_numer (
      .clock (clock),
      .ctrl  (ctrl),
      .front (front),
      .numer (numer)
   );

   // One constant divider per lane.
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      cstr_const_div u_const_div (
         .clock (clock),
         .en    (ctrl.en[STG_EST]),
         .num   (numer.num[g]),
         .sel   (numer.sel[g]),
         .quo   (quo[g])
      );
   end

   // Selection data rides along with the divider stage.
   always_ff @(posedge clock) begin
      if (ctrl.en[STG_EST]) begin
         side4_ff <= numer.side;
      end
   end

   // Place the zero, x and chroma parts by sector for HSV and HSL; other codes pass the lanes straight through.
   always_comb begin
      zv = quo[LANE_Z];
      xv = quo[LANE_X];
      cv = quo[LANE_C];
      out_in.red   = quo[0];
      out_in.green = quo[1];
      out_in.blue  = quo[2];
      if (side4_ff.op == OP_HSV || side4_ff.op == OP_HSL) begin
         if (side4_ff.oor) begin
            out_in = '{red: zv, green: zv, blue: zv};
         end else begin
            unique case (side4_ff.sector)
               3'd0:    out_in = '{red: cv, green: xv, blue: zv};
               3'd1:    out_in = '{red: xv, green: cv, blue: zv};
               3'd2:    out_in = '{red: zv, green: cv, blue: xv};
               3'd3:    out_in = '{red: zv, green: xv, blue: cv};
               3'd4:    out_in = '{red: xv, green: zv, blue: cv};
               3'd5:    out_in = '{red: cv, green: zv, blue: xv};
               default: out_in = '{red: zv, green: zv, blue: zv};
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[STG_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign req_stall = !ctrl.en[STG_DECODE];
   assign rsp_valid = ctrl.valid[STG_OUT];
   assign rsp_data  = out_ff;

endmodule

FILE: rtl/cstr_checker.sv
`include "color_space_to_rgb_unit_assert.svh"

module cstr_checker
   import cstr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A result held by a stall stays put.
   `CSTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   // The source keeps a stalled input steady.
   `CSTR_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_data), "stalled input changed")

   // Reset empties the pipeline.
   `CSTR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // With the output side moving, the input is never held off.
   `CSTR_ASSERT_SAME(a_no_stall_free, clock, reset, !rsp_stall, !req_stall, "input stalled while output drains")

   // The input is held off only when a finished result is waiting.
   `CSTR_ASSERT_SAME(a_stall_full, clock, reset, req_stall, rsp_valid, "input stalled with empty output")

endmodule

bind color_space_to_rgb_unit cstr_checker u_cstr_checker (.*);

FILE: bench/rgb_conversion_checker.sv
// Watches both channels of the color space converter, predicts the RGB value
// of every pixel that transfers in, and compares each result that transfers
// out against the oldest prediction still waiting.
module rgb_conversion_checker
   import cstr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Full scale of a channel, one hue sector and a full turn, in input units.
   localparam longint unsigned LEVEL_MAX  = 255;
   localparam longint unsigned HUE_SECTOR = 60 * 64;
   localparam longint unsigned HUE_TURN   = 360 * 64;

   typedef struct packed {
      req_type pixel;
      rsp_type rgb;
   } expected_rgb_type;

   expected_rgb_type expected_rgb[$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   // Exact integer conversion of one pixel; every channel is floored.
   function automatic rsp_type convert_pixel(req_type px);
      longint unsigned h, s, v, sector, frac, xf;
      longint unsigned twol, span, span_sat, keep_k;
      longint unsigned low_part, mid_part, top_part;
      longint unsigned red, green, blue;
      rsp_type rgb;
      h     = px.hue;
      s     = px.saturation;
      v     = px.brightness;
      red   = 0;
      green = 0;
      blue  = 0;
      case (op_type'(px.operation))
         OP_CMYK: begin
            keep_k = LEVEL_MAX - px.black;
            red    = ((LEVEL_MAX - px.cyan) * keep_k) / LEVEL_MAX;
            green  = ((LEVEL_MAX - px.magenta) * keep_k) / LEVEL_MAX;
            blue   = ((LEVEL_MAX - px.yellow) * keep_k) / LEVEL_MAX;
         end
         OP_HSV, OP_HSL: begin
            sector = h / HUE_SECTOR;
            frac   = h % HUE_SECTOR;
            xf     = sector[0] ? (HUE_SECTOR - frac) : frac;
            if (op_type'(px.operation) == OP_HSV) begin
               top_part = v;
               low_part = (v * (LEVEL_MAX - s)) / LEVEL_MAX;
               mid_part = (v * s * xf + v * (LEVEL_MAX - s) * HUE_SECTOR)
                          / (LEVEL_MAX * HUE_SECTOR);
            end else begin
               // Chroma span is min(2L, 2*MAX - 2L) scaled by saturation.
               twol     = 2 * v;
               span     = (twol <= LEVEL_MAX) ? twol : (2 * LEVEL_MAX - twol);
               span_sat = span * s;
               top_part = (twol * LEVEL_MAX + span_sat) / (2 * LEVEL_MAX);
               low_part = (twol * LEVEL_MAX - span_sat) / (2 * LEVEL_MAX);
               mid_part = (twol * LEVEL_MAX * HUE_SECTOR - span_sat * HUE_SECTOR
                           + 2 * span_sat * xf) / (2 * LEVEL_MAX * HUE_SECTOR);
            end
            // An out-of-range hue falls to the default gray at the low level.
            if (h >= HUE_TURN) begin
               red   = low_part;
               green = low_part;
               blue  = low_part;
            end else begin
               case (sector)
                  0: begin red = top_part; green = mid_part; blue = low_part; end
                  1: begin red = mid_part; green = top_part; blue = low_part; end
                  2: begin red = low_part; green = top_part; blue = mid_part; end
                  3: begin red = low_part; green = mid_part; blue = top_part; end
                  4: begin red = mid_part; green = low_part; blue = top_part; end
                  default: begin red = top_part; green = low_part; blue = mid_part; end
               endcase
            end
         end
         default: ;
      endcase
      rgb.red   = red[7:0];
      rgb.green = green[7:0];
      rgb.blue  = blue[7:0];
      return rgb;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: rgb mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic compare_channel(input string name, input req_type px,
                                  input logic [7:0] got, input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf(
            "%s got %0d expected %0d (op %0d hue %0d s %0d v %0d cmyk %0d %0d %0d %0d)",
            name, got, want, px.operation, px.hue, px.saturation, px.brightness,
            px.cyan, px.magenta, px.yellow, px.black));
      end
   endtask

   // Record each input transfer and check each output transfer in order.
   always @(posedge clock) begin
      expected_rgb_type head;
      if (reset) begin
         expected_rgb.delete();
      end else begin
         if (req_valid && !req_stall) begin
            expected_rgb.push_back('{pixel: req_data, rgb: convert_pixel(req_data)});
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rgb.size() == 0) begin
               report_mismatch($sformatf("unexpected result transfer %0d %0d %0d",
                  rsp_data.red, rsp_data.green, rsp_data.blue));
            end else begin
               head = expected_rgb.pop_front();
               compare_channel("red", head.pixel, rsp_data.red, head.rgb.red);
               compare_channel("green", head.pixel, rsp_data.green, head.rgb.green);
               compare_channel("blue", head.pixel, rsp_data.blue, head.rgb.blue);
            end
         end
      end
      pending_count <= expected_rgb.size();
   end

endmodule

FILE: bench/tb_color_space_to_rgb_unit.sv
// Drives pixels into the color space converter with random gaps and random
// result stalls, and gives the verdict from the checker's mismatch count.
module tb_color_space_to_rgb_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import cstr_pkg::*;

   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_PIXELS = 450;
   localparam int DRAIN_CYCLES  = 24;
   localparam int IDLE_LIMIT    = 2000;
   localparam int IDLE_PERCENT  = 31;
   localparam int HUE_SPAN      = 360 * 64;
   localparam int HUE_STEP      = 60 * 64;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    no_idle   = 1'b0;
   int      mismatch_count;
   int      pending_count;
   int      idle_run;

   color_space_to_rgb_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rgb_conversion_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The result side stalls at random, except during the quiet stretch.
   always @(negedge clock) begin
      rsp_stall = !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // End the run when no transfer happens on either side for too long.
   initial begin
      idle_run = 0;
      while (idle_run < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_run = 0;
         end else begin
            idle_run++;
         end
      end
      $display("color_space_to_rgb_unit verification failed");
      $finish;
   end

   function automatic req_type make_pixel(op_type op, int hue, int sat, int level,
                                          int cyan, int magenta, int yellow, int black);
      req_type px;
      px.operation  = op;
      px.hue        = hue[15:0];
      px.saturation = sat[7:0];
      px.brightness = level[7:0];
      px.cyan       = cyan[7:0];
      px.magenta    = magenta[7:0];
      px.yellow     = yellow[7:0];
      px.black      = black[7:0];
      return px;
   endfunction

   // Channel levels lean toward the two ends of the range.
   function automatic int random_level();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return 0;
      end else if (pick == 1) begin
         return 255;
      end
      return $urandom_range(0, 255);
   endfunction

   function automatic req_type random_pixel();
      int     pick;
      int     hue;
      op_type op;
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
         op = OP_HSV;
      end else if (pick < 76) begin
         op = OP_HSL;
      end else if (pick < 96) begin
         op = OP_CMYK;
      end else begin
         op = OP_NONE;
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         hue = $urandom_range(0, 65535);
      end else if (pick < 4) begin
         hue = $urandom_range(0, 5) * HUE_STEP + $urandom_range(0, 2) - 1;
         if (hue < 0) begin
            hue = 0;
         end
      end else begin
         hue = $urandom_range(0, HUE_SPAN - 1);
      end
      return make_pixel(op, hue, random_level(), random_level(), random_level(),
                        random_level(), random_level(), random_level());
   endfunction

   // Offer one pixel after random gaps and hold it until it transfers.
   task automatic send_pixel(input req_type px);
      while (!no_idle && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = px;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pixels: range ends, sector edges, out-of-range hue, all codes.
      send_pixel(make_pixel(OP_HSV, 0, 255, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSV, 0, 0, 0, 255, 255, 255, 255));
      send_pixel(make_pixel(OP_HSV, HUE_SPAN - 1, 255, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSV, HUE_STEP, 200, 180, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSV, 2 * HUE_STEP - 1, 255, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSV, 3 * HUE_STEP, 128, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSV, 5 * HUE_STEP + 17, 255, 100, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSV, HUE_SPAN, 255, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSV, 65535, 100, 200, 255, 255, 255, 255));
      send_pixel(make_pixel(OP_HSL, 0, 255, 127, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSL, 4 * HUE_STEP, 255, 128, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSL, 2 * HUE_STEP + 99, 255, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSL, HUE_STEP + 1, 255, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSL, 3 * HUE_STEP + 2000, 77, 200, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSL, HUE_SPAN, 200, 60, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_HSL, 65535, 255, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_CMYK, 65535, 255, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(OP_CMYK, 0, 0, 0, 255, 255, 255, 0));
      send_pixel(make_pixel(OP_CMYK, 1234, 9, 9, 0, 128, 255, 255));
      send_pixel(make_pixel(OP_CMYK, 0, 0, 0, 17, 200, 99, 64));
      send_pixel(make_pixel(OP_NONE, 4000, 255, 255, 255, 255, 255, 255));
      send_pixel(make_pixel(OP_NONE, 0, 0, 0, 0, 0, 0, 0));

      // Random pixels, with one long stretch in which neither side idles.
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         no_idle = (i >= 150) && (i < 300);
         send_pixel(random_pixel());
      end
      no_idle   = 1'b0;
      req_valid = 1'b0;

      // Drain the pipeline, then allow time for any stray result.
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("color_space_to_rgb_unit verification clean");
      end else begin
         $display("color_space_to_rgb_unit verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cstr_pkg.sv
rtl/cstr_pipe_ctrl.sv
rtl/cstr_front.sv
rtl/cstr_numer.sv
rtl/cstr_const_div.sv
rtl/color_space_to_rgb_unit.sv
rtl/cstr_checker.sv
bench/rgb_conversion_checker.sv
bench/tb_color_space_to_rgb_unit.sv
